// ===== hw/rtl/sbd_pkg.sv =====
`timescale 1ns / 1ps

package sbd_pkg;

    localparam int BUTTON_COUNT = 16;
    localparam int BTN_W        = $clog2(BUTTON_COUNT);
    localparam int COUNT_W      = 4;
    localparam logic [COUNT_W-1:0] LEVEL_RESET = COUNT_W'(3);

    // Item function codes
    typedef enum logic {
        FUNC_SCAN  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    // Per-lane command for one accepted transaction
    typedef struct packed {
        logic scan;   // integrate this lane's sample
        logic clear;  // read and clear this lane's click event
    } lane_cmd_t;

    // Scan word bit that carries a given button. The shift register wires
    // bits 15..12 to buttons 4..7, 11..8 to 3..0, 7..4 to 12..15, 3..0 to 11..8.
    function automatic logic [BTN_W-1:0] sample_bit_of(input logic [BTN_W-1:0] btn);
        logic [BTN_W-1:0] bit_idx;
        case (btn[3:2])
            2'd0:    bit_idx = BTN_W'(5'd8 + {1'b0, btn});
            2'd1:    bit_idx = BTN_W'(5'd19 - {1'b0, btn});
            2'd2:    bit_idx = BTN_W'({1'b0, btn} - 5'd8);
            default: bit_idx = BTN_W'(5'd19 - {1'b0, btn});
        endcase
        return bit_idx;
    endfunction

endpackage

// ===== hw/rtl/sbd_lane.sv =====
`timescale 1ns / 1ps

module sbd_lane
    import sbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_cmd_t          cmd,
    input  logic               released,
    input  logic [COUNT_W-1:0] level,
    output logic               pending
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               pressed_reg, pressed_next;
    logic               pending_reg, pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pressed_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pressed_reg <= pressed_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        pressed_next = pressed_reg;
        pending_next = pending_reg;
        if (cmd.scan)
        begin
            if (!released)
            begin
                // climb toward the level; at or above it, accept the press once
                if (count_reg < level)
                    count_next = count_reg + COUNT_W'(1);
                else if (!pressed_reg)
                begin
                    pressed_next = 1'b1;
                    pending_next = 1'b1;
                end
            end
            else if (count_reg != '0)
                count_next = count_reg - COUNT_W'(1);
            else
                pressed_next = 1'b0;
        end
        if (cmd.clear)
            pending_next = 1'b0;
    end

    assign pending = pending_reg;

endmodule

// ===== hw/rtl/sbd_merge.sv =====
`timescale 1ns / 1ps

module sbd_merge
    import sbd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic                    func,
    input  logic [BTN_W-1:0]        button_id,
    input  logic [BUTTON_COUNT-1:0] pending_vec,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic                    clicked,
    output logic                    can_load
);

    logic out_valid_reg, out_valid_next;
    logic clicked_reg, clicked_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        clicked_reg <= clicked_next;
    end

    always_comb
    begin
        clicked_next   = clicked_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            // pick the queried lane's event; scans always report zero
            clicked_next   = (func == FUNC_QUERY) ? pending_vec[button_id] : 1'b0;
            out_valid_next = 1'b1;
        end
    end

    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign clicked   = clicked_reg;

endmodule

// ===== hw/rtl/sixteen_button_debouncer_top.sv =====
// A transaction's result is registered and shows in the cycle after it is accepted.
// Throughput: one transaction per cycle unless the result stalls; all sixteen button lanes
// update in parallel from one scan word, and the output register frees itself in the cycle it is taken.
// Reset (rst_n, async, active low): all counters, debounced states and click events
// clear, the press level returns to 3, and the output register empties.
`timescale 1ns / 1ps

module sixteen_button_debouncer_top
    import sbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [15:0]        sample_word,
    input  logic [BTN_W-1:0]   button_id,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               clicked,
    // press level register write
    input  logic               wr_en,
    input  logic [COUNT_W-1:0] wr_data
);

    logic [COUNT_W-1:0]      level_reg, level_next;
    logic                    accept;
    logic [BUTTON_COUNT-1:0] pending_vec;
    lane_cmd_t               lane_cmd [BUTTON_COUNT];

    // Hold the debounce level; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= LEVEL_RESET;
        else
            level_reg <= level_next;
    end

    assign level_next = wr_en ? wr_data : level_reg;

    // Take a new transaction whenever the output register is empty or draining.
    assign accept = in_valid && in_ready;

    // Fan the transaction out to the lanes: a scan touches every lane, a query
    // clears only the addressed lane's click event.
    for (genvar b = 0; b < BUTTON_COUNT; b++)
    begin : g_lane
        localparam logic [BTN_W-1:0] LANE_ID  = BTN_W'(b);
        localparam logic [BTN_W-1:0] SAMPLE_IX = sample_bit_of(LANE_ID);

        always_comb
        begin
            lane_cmd[b].scan  = accept && (func == FUNC_SCAN);
            lane_cmd[b].clear = accept && (func == FUNC_QUERY) && (button_id == LANE_ID);
        end

        sbd_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (lane_cmd[b]),
            .released (sample_word[SAMPLE_IX]),
            .level    (level_reg),
            .pending  (pending_vec[b])
        );
    end

    // Select the queried event from the pre-update lane state and register it.
    sbd_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .func        (func),
        .button_id   (button_id),
        .pending_vec (pending_vec),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .clicked     (clicked),
        .can_load    (in_ready)
    );

endmodule

// ===== hw/rtl/sbd_checker.sv =====
`timescale 1ns / 1ps

module sbd_checker
    import sbd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             func,
    input logic [BTN_W-1:0] button_id,
    input logic             out_valid,
    input logic             out_ready,
    input logic             clicked
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(clicked))
        else $error("stalled result changed");

    // the block never refuses input while its output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // a scan reports a result of zero in the next cycle
    a_scan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (func == FUNC_SCAN) |=> out_valid && !clicked)
        else $error("scan result not zero");

    // a repeated query of the same button right after a query finds nothing
    a_requery_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (func == FUNC_QUERY)) ##1
        (in_acc && (func == FUNC_QUERY) && (button_id == $past(button_id)))
        |=> !clicked)
        else $error("click event not cleared by query");

endmodule

bind sixteen_button_debouncer_top sbd_checker u_sbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .button_id (button_id),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .clicked   (clicked)
);
